### hdl/slmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slmn_pkg
// Shared types and constants of the spectrum log-magnitude normalizer.
// ----------------------------------------------------------------------------
package slmn_pkg;

  localparam int FRAC_BITS = 16;
  localparam int IDX_W     = 18;
  localparam int CNT_W     = 19;
  localparam int DB_W      = 18;
  localparam int MAX_BINS  = 1 << IDX_W;

  localparam logic [DB_W-1:0] DB_MIN   = 18'h20000;
  localparam logic [17:0]     LOG_TO_DB = 18'd197283;
  localparam logic [15:0]     RANGE_Q8 = 16'd20480;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic              mode;
    logic signed [47:0] re_part;
    logic signed [47:0] im_part;
    logic              frame_end;
    logic [IDX_W-1:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic [15:0] level;
    logic        valid_res;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_LO, ST_SQ_HI, ST_SUM, ST_NORM, ST_FRAC,
    ST_SCALE, ST_STORE, ST_RD_MEM, ST_RD_CALC, ST_RD_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic sq_lo;
    logic sq_hi;
    logic sum;
    logic norm;
    logic frac_step;
    logic scale;
    logic store;
    logic rd_mem;
    logic rd_calc;
    logic rd_out;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frac_last;
  } stat_t;

endpackage

`default_nettype wire

### hdl/slmn_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slmn_ctrl
// Sequencer that steps one item through the datapath.
// ----------------------------------------------------------------------------
module slmn_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic            mode,
  input  wire slmn_pkg::stat_t stat,
  output slmn_pkg::ctrl_t      ctrl,
  output logic                 busy
);

  slmn_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= slmn_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      slmn_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (mode == slmn_pkg::MODE_READ) ? slmn_pkg::ST_RD_MEM
                                                     : slmn_pkg::ST_SQ_LO;
        end
      end
      slmn_pkg::ST_SQ_LO:   state_next = slmn_pkg::ST_SQ_HI;
      slmn_pkg::ST_SQ_HI:   state_next = slmn_pkg::ST_SUM;
      slmn_pkg::ST_SUM:     state_next = slmn_pkg::ST_NORM;
      slmn_pkg::ST_NORM:    state_next = slmn_pkg::ST_FRAC;
      slmn_pkg::ST_FRAC: begin
        if (stat.frac_last) begin
          state_next = slmn_pkg::ST_SCALE;
        end
      end
      slmn_pkg::ST_SCALE:   state_next = slmn_pkg::ST_STORE;
      slmn_pkg::ST_STORE:   state_next = slmn_pkg::ST_IDLE;
      slmn_pkg::ST_RD_MEM:  state_next = slmn_pkg::ST_RD_CALC;
      slmn_pkg::ST_RD_CALC: state_next = slmn_pkg::ST_RD_OUT;
      slmn_pkg::ST_RD_OUT:  state_next = slmn_pkg::ST_IDLE;
      default:              state_next = slmn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl           = '0;
    busy           = (state != slmn_pkg::ST_IDLE);
    ctrl.capture   = (state == slmn_pkg::ST_IDLE) && start;
    ctrl.sq_lo     = (state == slmn_pkg::ST_SQ_LO);
    ctrl.sq_hi     = (state == slmn_pkg::ST_SQ_HI);
    ctrl.sum       = (state == slmn_pkg::ST_SUM);
    ctrl.norm      = (state == slmn_pkg::ST_NORM);
    ctrl.frac_step = (state == slmn_pkg::ST_FRAC);
    ctrl.scale     = (state == slmn_pkg::ST_SCALE);
    ctrl.store     = (state == slmn_pkg::ST_STORE);
    ctrl.rd_mem    = (state == slmn_pkg::ST_RD_MEM);
    ctrl.rd_calc   = (state == slmn_pkg::ST_RD_CALC);
    ctrl.rd_out    = (state == slmn_pkg::ST_RD_OUT);
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.sq_lo, ctrl.sq_hi, ctrl.sum, ctrl.norm, ctrl.frac_step,
              ctrl.scale, ctrl.store, ctrl.rd_mem, ctrl.rd_calc, ctrl.rd_out}))
    else $error("more than one datapath command");
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    ctrl.capture |=> busy) else $error("not busy after accept");
  a_read_out: assert property (@(posedge clk) disable iff (rst)
    ctrl.rd_mem |=> ##1 ctrl.rd_out) else $error("read sequence broken");

endmodule

`default_nettype wire

### hdl/slmn_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// slmn_dp
// Datapath: squares, log2 by repeated squaring, dB scaling, level store,
// peak and count tracking, and the normalized read.
// ----------------------------------------------------------------------------
module slmn_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire slmn_pkg::in_item_t in_item,
  input  wire slmn_pkg::ctrl_t    ctrl,
  output slmn_pkg::stat_t         stat,
  output slmn_pkg::out_item_t     result,
  output logic                    result_strobe
);

  localparam int DBW_L = slmn_pkg::DB_W;

  slmn_pkg::in_item_t item;
  logic [47:0] ar, ai;
  logic [95:0] sq_r, sq_i;   // accumulated from 24-bit-split partial products
  logic [96:0] msq;
  logic [6:0]  e_pos;
  logic [31:0] mant;
  logic [4:0]  frac_cnt;
  logic [15:0] frac;
  logic signed [DBW_L-1:0] db_val;

  logic [DBW_L-1:0] db_store [slmn_pkg::MAX_BINS];
  logic signed [DBW_L-1:0] peak_db, rd_db;
  logic [slmn_pkg::CNT_W-1:0] entry_count;
  logic frame_done;
  logic rd_ok;
  logic signed [19:0] t_val;
  logic [31:0] lv_prod;

  // Partial products of the squares, 48x24 split in two halves.
  logic [71:0] pr_lo, pi_lo, pr_hi, pi_hi;
  assign pr_lo = ar * {48'd0, ar[23:0]};
  assign pi_lo = ai * {48'd0, ai[23:0]};
  assign pr_hi = ar * {48'd0, ar[47:24]};
  assign pi_hi = ai * {48'd0, ai[47:24]};

  // Leading-one search over the squared magnitude.
  logic [6:0] lead;
  always_comb begin
    lead = '0;
    for (int k = 0; k < 96; k++) begin
      if (msq[k]) lead = 7'(k);
    end
  end

  logic [63:0] mm;
  assign mm = {32'd0, mant} * {32'd0, mant};
  logic [32:0] msq_sh;
  assign msq_sh = mm[63:31];

  logic signed [23:0] lg;
  assign lg = 24'(signed'({1'b0, e_pos}) - 8'sd32) * 24'sd65536
            + signed'(24'({8'd0, frac}));
  logic signed [43:0] xprod;
  logic signed [43:0] xround;
  assign xround = xprod + 44'sd8388608;
  logic signed [19:0] xsh;
  assign xsh = xround[43:24];

  logic slot_free;
  assign slot_free = frame_done ? 1'b1
                   : (entry_count < slmn_pkg::CNT_W'(slmn_pkg::MAX_BINS));

  assign stat.frac_last = (frac_cnt == 5'd15);

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item <= in_item;
      ar <= in_item.re_part[47] ? 48'(-in_item.re_part) : in_item.re_part;
      ai <= in_item.im_part[47] ? 48'(-in_item.im_part) : in_item.im_part;
    end
    if (ctrl.sq_lo) begin
      sq_r <= 96'(pr_lo);
      sq_i <= 96'(pi_lo);
    end
    if (ctrl.sq_hi) begin
      sq_r <= sq_r + {pr_hi, 24'd0};
      sq_i <= sq_i + {pi_hi, 24'd0};
    end
    if (ctrl.sum) begin
      msq <= ((sq_r == '0) && (sq_i == '0)) ? 97'd1 : 97'(sq_r) + 97'(sq_i);
    end
    if (ctrl.norm) begin
      e_pos    <= msq[96] ? 7'd96 : lead;
      mant     <= msq[96] ? msq[96:65]
                : (lead >= 7'd31) ? 32'(msq >> (lead - 7'd31))
                : 32'(msq << (7'd31 - lead));
      frac_cnt <= '0;
      frac     <= '0;
    end
    if (ctrl.frac_step) begin
      frac_cnt <= frac_cnt + 5'd1;
      frac     <= {frac[14:0], msq_sh[32]};
      mant     <= msq_sh[32] ? msq_sh[32:1] : msq_sh[31:0];
    end
    if (ctrl.scale) begin
      xprod <= 44'(lg) * 44'(signed'({1'b0, slmn_pkg::LOG_TO_DB}));
    end
    if (ctrl.store) begin
      if (slot_free) begin
        db_store[frame_done ? '0 : entry_count[slmn_pkg::IDX_W-1:0]] <= db_val;
      end
    end
    if (ctrl.rd_mem) begin
      rd_db <= db_store[item.read_index];
    end
    if (ctrl.rd_calc) begin
      lv_prod <= 32'(t_val[15:0]) * 32'd65535 + 32'd10240;
    end
  end

  always_comb begin
    if (xsh < -20'sd131072)     db_val = DBW_L'(-20'sd131072);
    else if (xsh > 20'sd131071) db_val = DBW_L'(20'sd131071);
    else                        db_val = xsh[DBW_L-1:0];
  end

  assign rd_ok = frame_done &&
                 ({1'b0, item.read_index} < entry_count);
  assign t_val = 20'(rd_db) - 20'(peak_db) + signed'(20'(slmn_pkg::RANGE_Q8));

  logic [15:0] div_q;
  // lv_prod / 20480 = (lv_prod >> 12) / 5, by a reciprocal multiply with
  // 22 fraction bits, exact over the whole range of the quotient.
  logic [19:0] pre;
  logic [39:0] rq;
  assign pre  = lv_prod[31:12];
  assign rq   = 40'(pre) * 40'd838861;
  assign div_q = 16'(rq[39:22]);

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_db       <= slmn_pkg::DB_MIN;
      entry_count   <= '0;
      frame_done    <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= ctrl.rd_out;
      if (ctrl.store) begin
        if (frame_done) begin
          entry_count <= slmn_pkg::CNT_W'(1);
          peak_db     <= db_val;
        end else if (slot_free) begin
          entry_count <= entry_count + 1'b1;
          if (db_val > peak_db) peak_db <= db_val;
        end
        frame_done <= item.frame_end;
      end
    end
  end

  logic t_lo, t_hi;
  always_ff @(posedge clk) begin
    if (ctrl.rd_calc) begin
      t_lo <= (t_val <= 0);
      t_hi <= (t_val >= 20'sd20480);
    end
    if (ctrl.rd_out) begin
      result.valid_res <= rd_ok;
      if (!rd_ok || t_lo) result.level <= '0;
      else if (t_hi)      result.level <= 16'hFFFF;
      else                result.level <= div_q;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= slmn_pkg::CNT_W'(slmn_pkg::MAX_BINS))
    else $error("entry count overflow");
  a_zero_invalid: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !result.valid_res) |-> result.level == '0)
    else $error("invalid result carries a level");
  a_peak_first: assert property (@(posedge clk) disable iff (rst)
    (ctrl.store && frame_done) |=> peak_db == $past(db_val))
    else $error("peak not restarted");

endmodule

`default_nettype wire

### hdl/spectrum_log_magnitude_normalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_log_magnitude_normalizer_top
// Log-magnitude dB store with peak-relative normalized readout.
// ----------------------------------------------------------------------------
// Usage: drive in_item and raise start; the item is taken at an edge where
// start is high and busy is low. A load (mode 0) squares the bin, takes log2
// by sixteen squaring steps and scales to dB, then, while a slot is free,
// stores it and updates the peak and count; busy stays high throughout and
// no result is given. A read (mode 1) passes a memory read, a scaling step
// and an output register, and the result appears on result with done high
// for exactly one cycle. The receiver cannot stall; done marks the result
// only in that cycle. A new item is taken only once busy is low again, so
// loads are bound by the serial fraction loop. Reset clears the count, the
// peak and the frame flag; the level store itself is not cleared, since
// only entries of the current frame are ever read.
// ----------------------------------------------------------------------------
module spectrum_log_magnitude_normalizer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire slmn_pkg::in_item_t in_item,
  output logic                    busy,
  output logic                    done,
  output slmn_pkg::out_item_t     result
);

  slmn_pkg::ctrl_t ctrl;
  slmn_pkg::stat_t stat;

  slmn_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .mode (in_item.mode),
    .stat (stat),
    .ctrl (ctrl),
    .busy (busy)
  );

  slmn_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_item      (in_item),
    .ctrl         (ctrl),
    .stat         (stat),
    .result       (result),
    .result_strobe(done)
  );

endmodule

`default_nettype wire

### bench/spectrum_log_magnitude_normalizer_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectrum_log_magnitude_normalizer_top_tb
// Self-checking bench for the log-magnitude dB store and normalized readout.
// Frames of complex bins are loaded and then read back. A bit-exact
// predictor of the dB conversion, peak tracking and normalization supplies
// the expected level of every read, and each strobed result is checked
// against it in order.
// ----------------------------------------------------------------------------
module spectrum_log_magnitude_normalizer_top_tb;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_GOAL   = 1700;
  localparam int Q8_RANGE    = 20480;

  class level_scoreboard;
    slmn_pkg::out_item_t pending[$];
    int        db_mem[int];
    int        peak;
    int        count;
    bit        closed;
    int        errors;
    int        loads;
    int        reads;
    int        hits;

    function new();
      peak   = -131072;
      count  = 0;
      closed = 0;
      errors = 0;
      loads  = 0;
      reads  = 0;
      hits   = 0;
    endfunction

    // 10*log10(re^2+im^2) in Q10.8, by leading one, squaring loop and scaling.
    function int bin_db(logic signed [47:0] re, logic signed [47:0] im);
      logic [47:0] ar;
      logic [47:0] ai;
      logic [95:0] msq;
      logic [63:0] m;
      int          e;
      longint      frac;
      longint      lg;
      longint      x;
      ar  = re[47] ? 48'(-re) : 48'(re);
      ai  = im[47] ? 48'(-im) : 48'(im);
      msq = {48'b0, ar} * {48'b0, ar} + {48'b0, ai} * {48'b0, ai};
      if (msq == 0) msq = 96'd1;
      e = 0;
      for (int i = 0; i < 96; i++) if (msq[i]) e = i;
      if (e >= 31) m = 64'(msq >> (e - 31)) & 64'hFFFF_FFFF;
      else m = 64'(msq << (31 - e)) & 64'hFFFF_FFFF;
      frac = 0;
      for (int i = 0; i < 16; i++) begin
        m    = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 64'h1_0000_0000) begin
          frac = frac | 1;
          m    = m >> 1;
        end
      end
      lg = longint'(e - 2 * slmn_pkg::FRAC_BITS) * 65536 + frac;
      x  = (lg * 197283 + (longint'(1) << 23)) >>> 24;
      if (x < -131072) x = -131072;
      if (x > 131071) x = 131071;
      return int'(x);
    endfunction

    function void note(slmn_pkg::in_item_t it);
      int        d;
      longint    t;
      slmn_pkg::out_item_t r;
      if (it.mode == slmn_pkg::MODE_LOAD) begin
        loads++;
        if (closed) begin
          count  = 0;
          peak   = -131072;
          closed = 0;
        end
        if (count < slmn_pkg::MAX_BINS) begin
          d = bin_db(it.re_part, it.im_part);
          db_mem[count] = d;
          count++;
          if (d > peak) peak = d;
        end
        if (it.frame_end) closed = 1;
      end else begin
        reads++;
        r = '0;
        if (closed && int'(it.read_index) < count) begin
          hits++;
          t = longint'(db_mem[int'(it.read_index)]) - peak + Q8_RANGE;
          if (t <= 0) r.level = 16'd0;
          else if (t >= Q8_RANGE) r.level = 16'hFFFF;
          else r.level = 16'((t * 65535 + Q8_RANGE / 2) / Q8_RANGE);
          r.valid_res = 1'b1;
        end
        pending.push_back(r);
      end
    endfunction

    function void check(slmn_pkg::out_item_t got);
      slmn_pkg::out_item_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result level=%0d valid=%0b", $time, got.level,
                 got.valid_res);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.level !== exp_r.level) begin
        $display("%0t: level mismatch expected %0d actual %0d", $time, exp_r.level,
                 got.level);
        errors++;
      end
      if (got.valid_res !== exp_r.valid_res) begin
        $display("%0t: valid_res mismatch expected %0b actual %0b", $time,
                 exp_r.valid_res, got.valid_res);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  slmn_pkg::in_item_t  in_item = '0;
  logic      busy;
  logic      done;
  slmn_pkg::out_item_t result;

  level_scoreboard sb = new();
  int  cycles = 0;
  int  sent = 0;
  bit  quiet = 0;

  spectrum_log_magnitude_normalizer_top dut (
    .clk(clk), .rst(rst), .start(start), .in_item(in_item),
    .busy(busy), .done(done), .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check(result);
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Wide random value with a random magnitude, so both small and huge bins occur.
  function automatic logic signed [47:0] rand_part();
    logic signed [47:0] v;
    v = 48'({$urandom, $urandom});
    if ($urandom_range(0, 19) == 0) return '0;
    return v >>> $urandom_range(0, 47);
  endfunction

  task automatic send(slmn_pkg::in_item_t it);
    if (!quiet && $urandom_range(0, 99) < 37) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    sb.note(it);
    sent++;
  endtask

  task automatic load_bin(logic signed [47:0] re, logic signed [47:0] im, bit last);
    slmn_pkg::in_item_t it;
    it            = '0;
    it.mode       = slmn_pkg::MODE_LOAD;
    it.re_part    = re;
    it.im_part    = im;
    it.frame_end  = last;
    it.read_index = 18'($urandom);
    send(it);
  endtask

  task automatic read_bin(logic [17:0] idx);
    slmn_pkg::in_item_t it;
    it            = '0;
    it.mode       = slmn_pkg::MODE_READ;
    it.re_part    = rand_part();
    it.im_part    = rand_part();
    it.frame_end  = 1'($urandom);
    it.read_index = idx;
    send(it);
  endtask

  initial begin
    int n;
    int k;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: read before any frame, field extremes, zero floor, reads past count.
    read_bin(18'd0);
    load_bin(48'sd0, 48'sd0, 0);
    load_bin(48'sd1, 48'sd0, 0);
    load_bin(-48'sd1, -48'sd1, 0);
    read_bin(18'd1);
    load_bin(48'sh7FFF_FFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 0);
    load_bin(48'sh8000_0000_0000, 48'sh8000_0000_0000, 0);
    load_bin(48'sh7FFF_FFFF_FFFF, 48'sh8000_0000_0000, 0);
    load_bin(48'sd65536, -48'sd300, 1);
    for (int i = 0; i < 8; i++) read_bin(18'(i));
    read_bin(18'h3FFFF);
    load_bin(48'sd12345, 48'sd0, 1);
    read_bin(18'd0);
    read_bin(18'd1);

    // Random frames with reads, plus open-frame reads and stray indexes.
    while (sent < ITEM_GOAL) begin
      quiet = (sent > 700 && sent < 1000);
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) read_bin(18'($urandom_range(0, 15)));
        load_bin(rand_part(), rand_part(), i == n - 1);
      end
      k = $urandom_range(1, 10);
      for (int i = 0; i < k; i++) begin
        case ($urandom_range(0, 9))
          0:       read_bin(18'($urandom));
          1:       read_bin(18'(n + $urandom_range(0, 3)));
          default: read_bin(18'($urandom_range(0, n - 1)));
        endcase
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d loads and %0d reads, %0d of them within a closed frame.",
             sb.loads, sb.reads, sb.hits);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
